### design/lfnt_pkg.sv
// ----------------------------------------------------------------------------
// lfnt_pkg
// shared types and constants of the line follow node turn controller
// ----------------------------------------------------------------------------
package lfnt_pkg;

    localparam int SpeedW = 8;
    localparam int TickW  = 16;
    localparam int DriveW = 9;
    localparam int NodeW  = 8;
    localparam int SenseW = 8;
    localparam int CfgIdxW = 3;

    // command codes of the input channel
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_FOLLOW = 2'd1,
        OP_LEFT   = 2'd2,
        OP_RIGHT  = 2'd3
    } t_opcode;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_STRAIGHT_SPEED  = 3'd0,
        CFG_FOLLOW_CORRECT  = 3'd1,
        CFG_ALIGN_SPEED     = 3'd2,
        CFG_CORRECT_HOLD    = 3'd3,
        CFG_OVERRUN         = 3'd4,
        CFG_LEFT_BLIND      = 3'd5,
        CFG_RIGHT_BLIND     = 3'd6,
        CFG_UNUSED          = 3'd7
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [SpeedW-1:0] RstStraightSpeed = 8'd255;
    localparam logic [SpeedW-1:0] RstFollowCorrect = 8'd125;
    localparam logic [SpeedW-1:0] RstAlignSpeed    = 8'd100;
    localparam logic [TickW-1:0]  RstCorrectHold   = 16'd50;
    localparam logic [TickW-1:0]  RstOverrun       = 16'd260;
    localparam logic [TickW-1:0]  RstLeftBlind     = 16'd250;
    localparam logic [TickW-1:0]  RstRightBlind    = 16'd100;

    // sensor level that counts as black
    localparam logic [SenseW-1:0] SenseBlack = 8'd255;

endpackage

### design/lfnt_cmd_if.sv
// ----------------------------------------------------------------------------
// lfnt_cmd_if
// command and sensor tick channel
// ----------------------------------------------------------------------------
interface lfnt_cmd_if
    import lfnt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [NodeW-1:0]    target_nodes;
    logic [SenseW-1:0]   sense_left;
    logic [SenseW-1:0]   sense_center;
    logic [SenseW-1:0]   sense_right;

    modport source (
        output valid, opcode, target_nodes, sense_left, sense_center, sense_right,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_nodes, sense_left, sense_center, sense_right,
        output ready
    );
endinterface

### design/lfnt_res_if.sv
// ----------------------------------------------------------------------------
// lfnt_res_if
// wheel drive result channel
// ----------------------------------------------------------------------------
interface lfnt_res_if
    import lfnt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    logic                     busy_res;
    logic                     done_res;
    logic [NodeW-1:0]         nodes_seen;

    modport source (
        output valid, left_drive, right_drive, busy_res, done_res, nodes_seen,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, busy_res, done_res, nodes_seen,
        output ready
    );
endinterface

### design/lfnt_cfg_if.sv
// ----------------------------------------------------------------------------
// lfnt_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface lfnt_cfg_if
    import lfnt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [TickW-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### design/line_follow_node_turn_controller.sv
// ----------------------------------------------------------------------------
// line_follow_node_turn_controller
// three sensor line follower with node counting and spin turns
// ----------------------------------------------------------------------------
// Each beat on i_cmd is either a sensor tick or a command (follow N nodes,
// turn left, turn right), and each accepted beat yields exactly one result
// beat on o_res carrying both wheel drives, busy, done and the node count.
// The controller takes one beat per clock: the next state and the result are
// formed in one pass of logic from the beat and the stored maneuver state,
// and land together in the result register in the cycle after acceptance. That
// result register is the only stage, so a new beat is accepted in the same
// cycle a pending result is taken; i_cmd.ready drops only while a result sits
// unconsumed. Configuration writes on i_cfg are always accepted and belong to
// idle periods; an index past the last register is dropped.
// ----------------------------------------------------------------------------
module line_follow_node_turn_controller
    import lfnt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfnt_cmd_if.sink   i_cmd,
    lfnt_cfg_if.sink   i_cfg,
    lfnt_res_if.source o_res
);

    // maneuver phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FOLLOW  = 3'd1,
        PH_NODE    = 3'd2,
        PH_OVERRUN = 3'd3,
        PH_SPIN    = 3'd4,
        PH_ALIGN   = 3'd5
    } t_phase;

    // sensor pattern codes: left, center, right
    localparam logic [2:0] PatCenter = 3'b010;
    localparam logic [2:0] PatRight  = 3'b001;
    localparam logic [2:0] PatLeft   = 3'b100;
    localparam logic [2:0] PatAll    = 3'b111;

    // configuration registers
    logic [SpeedW-1:0] r_straight_speed;
    logic [SpeedW-1:0] r_follow_correct;
    logic [SpeedW-1:0] r_align_speed;
    logic [TickW-1:0]  r_correct_hold;
    logic [TickW-1:0]  r_overrun;
    logic [TickW-1:0]  r_left_blind;
    logic [TickW-1:0]  r_right_blind;

    // maneuver state
    t_phase                   r_phase, n_phase;
    logic [TickW-1:0]         r_hold, n_hold;
    logic [NodeW-1:0]         r_nodes, n_nodes;
    logic [NodeW-1:0]         r_goal, n_goal;
    logic                     r_turn_right, n_turn_right;
    logic signed [DriveW-1:0] r_drv_l, n_drv_l;
    logic signed [DriveW-1:0] r_drv_r, n_drv_r;
    logic                     n_done;

    // result register
    logic                     r_out_valid;
    logic                     r_out_busy;
    logic                     r_out_done;

    logic                     cmd_accept;
    logic                     cfg_accept;
    logic [2:0]               pat;
    logic signed [DriveW-1:0] spd_s;
    logic signed [DriveW-1:0] spd_neg;
    logic signed [DriveW-1:0] spd_fc;
    logic signed [DriveW-1:0] spd_al;
    logic [NodeW-1:0]         nodes_inc;
    logic [2:0]               spin_pat;
    t_opcode                  op;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid;

    assign op  = t_opcode'(i_cmd.opcode);
    assign pat = {i_cmd.sense_left == SenseBlack,
                  i_cmd.sense_center == SenseBlack,
                  i_cmd.sense_right == SenseBlack};

    assign spd_s     = $signed({1'b0, r_straight_speed});
    assign spd_neg   = -spd_s;
    assign spd_fc    = $signed({1'b0, r_follow_correct});
    assign spd_al    = $signed({1'b0, r_align_speed});
    assign nodes_inc = r_nodes + NodeW'(1);
    assign spin_pat  = r_turn_right ? PatRight : PatLeft;

    // next maneuver state for the beat at the input
    always_comb begin
        n_phase      = r_phase;
        n_hold       = r_hold;
        n_nodes      = r_nodes;
        n_goal       = r_goal;
        n_turn_right = r_turn_right;
        n_drv_l      = r_drv_l;
        n_drv_r      = r_drv_r;
        n_done       = 1'b0;

        if (op != OP_TICK) begin
            // commands only start from idle
            if (r_phase == PH_IDLE) begin
                n_nodes = '0;
                if (op == OP_FOLLOW) begin
                    n_phase = PH_FOLLOW;
                    n_goal  = i_cmd.target_nodes;
                    n_hold  = '0;
                end else begin
                    n_phase      = PH_SPIN;
                    n_turn_right = (op == OP_RIGHT);
                    if (op == OP_RIGHT) begin
                        n_drv_l = spd_s;
                        n_drv_r = spd_neg;
                        n_hold  = r_right_blind;
                    end else begin
                        n_drv_l = spd_neg;
                        n_drv_r = spd_s;
                        n_hold  = r_left_blind;
                    end
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_hold != '0) begin
                // held drive, samples ignored
                n_hold = r_hold - TickW'(1);
            end else begin
                case (r_phase)
                    PH_FOLLOW: begin
                        if (pat == PatCenter) begin
                            n_drv_l = spd_s;
                            n_drv_r = spd_s;
                        end else if (pat == PatRight) begin
                            n_drv_l = spd_fc;
                            n_drv_r = '0;
                            n_hold  = r_correct_hold;
                        end else if (pat == PatLeft) begin
                            n_drv_l = '0;
                            n_drv_r = spd_fc;
                            n_hold  = r_correct_hold;
                        end else if (pat == PatAll) begin
                            n_nodes = nodes_inc;
                            if (nodes_inc == r_goal) begin
                                n_drv_l = spd_s;
                                n_drv_r = spd_s;
                                n_phase = PH_OVERRUN;
                                n_hold  = r_overrun;
                            end else begin
                                n_phase = PH_NODE;
                            end
                        end
                    end
                    PH_NODE: begin
                        n_drv_l = spd_s;
                        n_drv_r = spd_s;
                        if (pat != PatAll) begin
                            n_phase = PH_FOLLOW;
                        end
                    end
                    PH_OVERRUN: begin
                        n_drv_l = '0;
                        n_drv_r = '0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_SPIN, PH_ALIGN: begin
                        if (r_phase == PH_SPIN && pat == spin_pat) begin
                            // still on the turn side, keep spinning
                            n_drv_l = r_turn_right ? spd_s : spd_neg;
                            n_drv_r = r_turn_right ? spd_neg : spd_s;
                        end else begin
                            n_phase = PH_ALIGN;
                            if (pat == PatCenter) begin
                                n_drv_l = '0;
                                n_drv_r = '0;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end else if (pat == PatRight) begin
                                n_drv_l = spd_al;
                                n_drv_r = '0;
                                n_hold  = r_correct_hold;
                            end else if (pat == PatLeft) begin
                                n_drv_l = '0;
                                n_drv_r = spd_al;
                                n_hold  = r_correct_hold;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // state, result register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_hold           <= '0;
            r_nodes          <= '0;
            r_goal           <= '0;
            r_turn_right     <= 1'b0;
            r_drv_l          <= '0;
            r_drv_r          <= '0;
            r_out_valid      <= 1'b0;
            r_out_busy       <= 1'b0;
            r_out_done       <= 1'b0;
            r_straight_speed <= RstStraightSpeed;
            r_follow_correct <= RstFollowCorrect;
            r_align_speed    <= RstAlignSpeed;
            r_correct_hold   <= RstCorrectHold;
            r_overrun        <= RstOverrun;
            r_left_blind     <= RstLeftBlind;
            r_right_blind    <= RstRightBlind;
        end else begin
            if (cmd_accept) begin
                r_phase      <= n_phase;
                r_hold       <= n_hold;
                r_nodes      <= n_nodes;
                r_goal       <= n_goal;
                r_turn_right <= n_turn_right;
                r_drv_l      <= n_drv_l;
                r_drv_r      <= n_drv_r;
                r_out_busy   <= (n_phase != PH_IDLE);
                r_out_done   <= n_done;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end

            if (cfg_accept) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_STRAIGHT_SPEED: r_straight_speed <= i_cfg.data[SpeedW-1:0];
                    CFG_FOLLOW_CORRECT: r_follow_correct <= i_cfg.data[SpeedW-1:0];
                    CFG_ALIGN_SPEED:    r_align_speed    <= i_cfg.data[SpeedW-1:0];
                    CFG_CORRECT_HOLD:   r_correct_hold   <= i_cfg.data;
                    CFG_OVERRUN:        r_overrun        <= i_cfg.data;
                    CFG_LEFT_BLIND:     r_left_blind     <= i_cfg.data;
                    CFG_RIGHT_BLIND:    r_right_blind    <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // drive and node count come straight from the stored state
    assign o_res.valid       = r_out_valid;
    assign o_res.left_drive  = r_drv_l;
    assign o_res.right_drive = r_drv_r;
    assign o_res.busy_res    = r_out_busy;
    assign o_res.done_res    = r_out_done;
    assign o_res.nodes_seen  = r_nodes;

endmodule
